// File: design/tbfs_pkg.sv
package tbfs_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned RF_W       = 24;
    localparam int unsigned LEN_W      = 11;
    localparam int unsigned NL_W       = 7;
    localparam int unsigned PC_W       = 24;
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned DIR_W      = 32;
    localparam int unsigned SMP_W      = 32;
    localparam int unsigned FV_W       = 40;
    localparam int unsigned LEN_MIN    = 2;

    localparam logic [RF_W-1:0]  RF_RESET     = 24'd65536;
    localparam logic [LEN_W-1:0] LEN_RESET    = 11'd1024;
    localparam logic [NL_W-1:0]  LINES_RESET  = 7'd64;
    localparam logic [PC_W-1:0]  POINTS_RESET = 24'd1;

    typedef enum logic [1:0] {
        KIND_DIR    = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_POINT  = 2'd2
    } tbfs_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RES_FACTOR    = 2'd0,
        CFG_LINE_LENGTH   = 2'd1,
        CFG_LINES_IN_USE  = 2'd2,
        CFG_POINTS_IN_USE = 2'd3
    } tbfs_cfg_idx_t;

    typedef struct packed {
        logic [1:0]                kind;
        logic [5:0]                line_index;
        logic [9:0]                sample_index;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
        logic signed [SMP_W-1:0]   sample_value;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } tbfs_in_t;

    typedef struct packed {
        logic signed [FV_W-1:0] field_value;
        logic                   clipped;
        logic                   last_point;
    } tbfs_out_t;

    typedef struct packed {
        logic             valid;
        logic             clip;
        logic [LEN_W-1:0] idx;
    } tbfs_idx_t;

endpackage

// File: design/tbfs_proj.sv
module tbfs_proj (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                dir_valid,
    input  logic [3*tbfs_pkg::DIR_W-1:0]        dir,
    input  logic signed [tbfs_pkg::COORD_W-1:0] coord_x,
    input  logic signed [tbfs_pkg::COORD_W-1:0] coord_y,
    input  logic signed [tbfs_pkg::COORD_W-1:0] coord_z,
    input  logic [tbfs_pkg::RF_W-1:0]           res_factor,
    input  logic [tbfs_pkg::LEN_W-1:0]          line_len,
    output tbfs_pkg::tbfs_idx_t                 idx_out
);
    import tbfs_pkg::*;

    localparam int unsigned PROD_W = 64;
    localparam int unsigned SUM_W  = 66;
    localparam int unsigned PART_W = 32 + RF_W;
    localparam int unsigned RND_W  = 64 + RF_W;
    localparam int unsigned Q_W    = RND_W - 62;
    localparam int unsigned IDXS_W = Q_W + 2;

    logic signed [DIR_W-1:0] dx, dy, dz;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     neg3_reg, neg4_reg, neg5_reg;
    logic [63:0]              mag_reg;
    logic [PART_W-1:0]        t0_reg, t1_reg;
    logic [Q_W-1:0]           q_reg;
    logic                     clip_reg;
    logic [LEN_W-1:0]         idx_reg;

    logic signed [SUM_W-1:0]  sum_c;
    logic signed [SUM_W-1:0]  mag_c;
    logic [RND_W-1:0]         rnd_c;
    logic signed [IDXS_W-1:0] sq_c, half_c, idxs_c;
    logic [LEN_W-1:0]         lenm1_c;
    logic [LEN_W-1:0]         idx_c;
    logic                     clip_c;

    assign dx = $signed(dir[DIR_W-1:0]);
    assign dy = $signed(dir[2*DIR_W-1:DIR_W]);
    assign dz = $signed(dir[3*DIR_W-1:2*DIR_W]);

    assign sum_c = SUM_W'(px_reg) + SUM_W'(py_reg) + SUM_W'(pz_reg);
    assign mag_c = (sum_reg > 0) ? sum_reg : -sum_reg;
    assign rnd_c = RND_W'(t0_reg) + {t1_reg, 32'b0} + (RND_W'(1) << 61);

    always_comb
    begin
        sq_c    = neg5_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        half_c  = $signed({{(IDXS_W-LEN_W){1'b0}}, line_len >> 1}) + IDXS_W'(1);
        idxs_c  = sq_c + half_c;
        lenm1_c = line_len - LEN_W'(1);
        priority if (idxs_c < 0)
        begin
            idx_c  = '0;
            clip_c = 1'b1;
        end
        else if (idxs_c > $signed({{(IDXS_W-LEN_W){1'b0}}, lenm1_c}))
        begin
            idx_c  = lenm1_c;
            clip_c = 1'b1;
        end
        else
        begin
            idx_c  = idxs_c[LEN_W-1:0];
            clip_c = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= dir_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= coord_x * dx;
        py_reg   <= coord_y * dy;
        pz_reg   <= coord_z * dz;
        sum_reg  <= sum_c;
        neg3_reg <= sum_reg > 0;
        mag_reg  <= mag_c[63:0];
        neg4_reg <= neg3_reg;
        t0_reg   <= mag_reg[31:0] * res_factor;
        t1_reg   <= mag_reg[63:32] * res_factor;
        neg5_reg <= neg4_reg;
        q_reg    <= rnd_c[RND_W-1:62];
        clip_reg <= clip_c;
        idx_reg  <= idx_c;
    end

    assign idx_out.valid = v6_reg;
    assign idx_out.clip  = clip_reg;
    assign idx_out.idx   = idx_reg;

endmodule

// File: design/tbfs_smp_store.sv
module tbfs_smp_store #(
    parameter int unsigned DEPTH = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            we,
    input  logic [$clog2(DEPTH)-1:0]        waddr,
    input  logic [tbfs_pkg::SMP_W-1:0]      wdata,
    input  logic                            re,
    input  logic [$clog2(DEPTH)-1:0]        raddr,
    output logic                            rvalid,
    output logic [tbfs_pkg::SMP_W-1:0]      rdata
);
    import tbfs_pkg::*;

    logic [SMP_W-1:0] mem [DEPTH];
    logic             rvalid_reg;
    logic [SMP_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= re;
        end
    end

    assign rvalid = rvalid_reg;
    assign rdata  = rdata_reg;

endmodule

// File: design/turning_bands_field_sum.sv
// Turning-bands field sum.
// Input channel (item_valid / item_stall / item) carries three kinds of item:
// direction loads, sample loads and point queries. A load writes the
// direction memory or the sample memory; it gives no result.
// A point query is projected onto every line in use, one line issued per
// cycle through a direction memory read, a six-stage projection pipeline and
// a sample memory read; the samples are summed into one result.
// The sample memory has a single read port and reads one line per cycle.
// Input stays stalled while a point is in work; loads and the next point
// are taken once it is finished.
// Output channel (result_valid / result_stall / result) is one register: a
// finished result waits there while the receiver stalls, and the block keeps
// taking loads; a further point finishes only once that register is free.
// Reset clears the control state and the point counter and sets the
// configuration registers to their reset values; both memories hold
// undefined data until loaded. Configuration (cfg_we / cfg_index / cfg_data)
// is written by the user only while idle; the block does not enforce it.
module turning_bands_field_sum #(
    parameter int unsigned MAX_LINES    = 64,
    parameter int unsigned MAX_LINE_LEN = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  tbfs_pkg::tbfs_in_t                 item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output tbfs_pkg::tbfs_out_t                result,
    input  logic                               cfg_we,
    input  logic [tbfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tbfs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tbfs_pkg::*;

    localparam int unsigned LINE_W    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int unsigned SMP_DEPTH = MAX_LINES * MAX_LINE_LEN;
    localparam int unsigned ADDR_W    = $clog2(SMP_DEPTH);
    localparam int unsigned CALC_W    = ADDR_W + 17;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [RF_W-1:0]  res_factor_reg;
    logic [LEN_W-1:0] line_length_reg;
    logic [NL_W-1:0]  lines_in_use_reg;
    logic [PC_W-1:0]  points_in_use_reg;

    logic [LEN_W-1:0] eff_len;
    logic [NL_W-1:0]  eff_lines;

    logic [NL_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic [NL_W-1:0]   ret_cnt_reg, ret_cnt_next;
    logic [CALC_W-1:0] base_reg, base_next;
    logic [FV_W-1:0]   acc_reg, acc_next;
    logic              clip_reg, clip_next;
    logic [PC_W-1:0]   point_cnt_reg, point_cnt_next;
    logic              out_valid_reg, out_valid_next;
    tbfs_out_t         out_reg, out_next;

    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg;

    logic [3*DIR_W-1:0] dir_mem [MAX_LINES];
    logic [3*DIR_W-1:0] dir_rdata_reg;
    logic               dir_rvalid_reg;
    logic [LINE_W-1:0]  dir_raddr;
    logic               dir_we;
    logic               issue;

    logic              item_xfer;
    logic              point_xfer;
    logic              smp_we;
    logic [CALC_W-1:0] smp_waddr_c;
    logic [CALC_W-1:0] smp_raddr_c;
    logic              smp_rvalid;
    logic [SMP_W-1:0]  smp_rdata;
    tbfs_idx_t         proj_out;

    logic [PC_W-1:0] np;
    logic            last;

    assign item_stall = (state_reg != ST_IDLE);
    assign item_xfer  = item_valid && !item_stall;
    assign point_xfer = item_xfer && (item.kind == KIND_POINT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_factor_reg    <= RF_RESET;
            line_length_reg   <= LEN_RESET;
            lines_in_use_reg  <= LINES_RESET;
            points_in_use_reg <= POINTS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (tbfs_cfg_idx_t'(cfg_index))
                CFG_RES_FACTOR:    res_factor_reg    <= cfg_data[RF_W-1:0];
                CFG_LINE_LENGTH:   line_length_reg   <= cfg_data[LEN_W-1:0];
                CFG_LINES_IN_USE:  lines_in_use_reg  <= cfg_data[NL_W-1:0];
                CFG_POINTS_IN_USE: points_in_use_reg <= cfg_data[PC_W-1:0];
                default:           res_factor_reg    <= res_factor_reg;
            endcase
        end
    end

    always_comb
    begin
        priority if (32'(line_length_reg) < LEN_MIN)
        begin
            eff_len = LEN_W'(LEN_MIN);
        end
        else if (32'(line_length_reg) > MAX_LINE_LEN)
        begin
            eff_len = LEN_W'(MAX_LINE_LEN);
        end
        else
        begin
            eff_len = line_length_reg;
        end
    end

    assign eff_lines = (32'(lines_in_use_reg) > MAX_LINES) ? NL_W'(MAX_LINES)
                                                         : lines_in_use_reg;

    assign dir_we    = item_xfer && (item.kind == KIND_DIR)
                       && (32'(item.line_index) < MAX_LINES);
    assign issue     = (state_reg == ST_RUN) && (issue_cnt_reg < eff_lines);
    assign dir_raddr = LINE_W'(issue_cnt_reg);

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[LINE_W'(item.line_index)] <= {item.dir_z, item.dir_y, item.dir_x};
        end
        if (issue)
        begin
            dir_rdata_reg <= dir_mem[dir_raddr];
        end
        if (point_xfer)
        begin
            cx_reg <= item.coord_x;
            cy_reg <= item.coord_y;
            cz_reg <= item.coord_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_rvalid_reg <= 1'b0;
        end
        else
        begin
            dir_rvalid_reg <= issue;
        end
    end

    tbfs_proj u_proj (
        .clk        (clk),
        .rst_n      (rst_n),
        .dir_valid  (dir_rvalid_reg),
        .dir        (dir_rdata_reg),
        .coord_x    (cx_reg),
        .coord_y    (cy_reg),
        .coord_z    (cz_reg),
        .res_factor (res_factor_reg),
        .line_len   (eff_len),
        .idx_out    (proj_out)
    );

    assign smp_we      = item_xfer && (item.kind == KIND_SAMPLE)
                         && (32'(item.line_index) < MAX_LINES)
                         && (32'(item.sample_index) < MAX_LINE_LEN);
    assign smp_waddr_c = CALC_W'(item.line_index) * CALC_W'(MAX_LINE_LEN)
                         + CALC_W'(item.sample_index);
    assign smp_raddr_c = base_reg + CALC_W'(proj_out.idx);

    tbfs_smp_store #(
        .DEPTH (SMP_DEPTH)
    ) u_smp_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (smp_we),
        .waddr  (smp_waddr_c[ADDR_W-1:0]),
        .wdata  (item.sample_value),
        .re     (proj_out.valid),
        .raddr  (smp_raddr_c[ADDR_W-1:0]),
        .rvalid (smp_rvalid),
        .rdata  (smp_rdata)
    );

    assign np   = (points_in_use_reg == '0) ? PC_W'(1) : points_in_use_reg;
    assign last = ((PC_W+1)'(point_cnt_reg) + (PC_W+1)'(1)) >= (PC_W+1)'(np);

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        ret_cnt_next   = ret_cnt_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        clip_next      = clip_reg;
        point_cnt_next = point_cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (point_xfer)
                begin
                    state_next     = ST_RUN;
                    issue_cnt_next = '0;
                    ret_cnt_next   = '0;
                    base_next      = '0;
                    acc_next       = '0;
                    clip_next      = 1'b0;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    issue_cnt_next = issue_cnt_reg + NL_W'(1);
                end
                if (proj_out.valid)
                begin
                    base_next = base_reg + CALC_W'(MAX_LINE_LEN);
                    clip_next = clip_reg | proj_out.clip;
                end
                if (smp_rvalid)
                begin
                    acc_next     = acc_reg
                                   + {{(FV_W-SMP_W){smp_rdata[SMP_W-1]}}, smp_rdata};
                    ret_cnt_next = ret_cnt_reg + NL_W'(1);
                end
                if (ret_cnt_reg == eff_lines)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next.field_value = acc_reg;
                    out_next.clipped     = clip_reg;
                    out_next.last_point  = last;
                    out_valid_next       = 1'b1;
                    point_cnt_next       = last ? '0 : point_cnt_reg + PC_W'(1);
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            ret_cnt_reg   <= '0;
            point_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            ret_cnt_reg   <= ret_cnt_next;
            point_cnt_reg <= point_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        acc_reg  <= acc_next;
        clip_reg <= clip_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: design/tbfs_checker.sv
module tbfs_props (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input tbfs_pkg::tbfs_in_t  item,
    input logic                result_valid,
    input logic                result_stall,
    input tbfs_pkg::tbfs_out_t result
);
    import tbfs_pkg::*;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result changed");

    // a point transfer starts work, so the input stalls next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.kind == KIND_POINT) |=> item_stall)
        else $error("input not stalled after point transfer");

    // a load never raises a result
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.kind != KIND_POINT) && !result_valid
        |=> !result_valid)
        else $error("result raised by a load");

endmodule

bind turning_bands_field_sum tbfs_props u_tbfs_props (.*);

// File: tb/tbfs_checker.sv
module tbfs_checker
    import tbfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_stall,
    input  tbfs_in_t              item,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  tbfs_out_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           errors,
    output int unsigned           pending
);

    localparam int unsigned LINES = 64;
    localparam int unsigned LEN   = 1024;

    logic signed [DIR_W-1:0] dir_store [LINES][3];
    logic signed [SMP_W-1:0] sample_store [LINES*LEN];
    logic [RF_W-1:0]         res_factor;
    logic [LEN_W-1:0]        line_len;
    logic [NL_W-1:0]         line_count;
    logic [PC_W-1:0]         field_points;
    logic [PC_W-1:0]         point_pos;
    tbfs_out_t               field_q [$];

    task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t checker: %s, got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    // rounded signed step count of one point along one line
    function automatic longint band_step(input tbfs_in_t p, input int unsigned line);
        logic signed [63:0] px, py, pz;
        logic signed [66:0] dot;
        logic               neg;
        logic [89:0]        scaled;
        px = $signed(p.coord_x) * $signed(dir_store[line][0]);
        py = $signed(p.coord_y) * $signed(dir_store[line][1]);
        pz = $signed(p.coord_z) * $signed(dir_store[line][2]);
        dot = -(px + py + pz);
        neg = dot[66];
        if (neg)
            dot = -dot;
        scaled = 90'(dot[63:0]) * 90'(res_factor) + (90'd1 << 61);
        return neg ? -longint'(scaled[89:62]) : longint'(scaled[89:62]);
    endfunction

    function automatic tbfs_out_t next_field(input tbfs_in_t p);
        longint          span, idx;
        int unsigned     nlines, k;
        logic [FV_W-1:0] sum;
        logic [SMP_W-1:0] s;
        logic [PC_W-1:0] np;
        tbfs_out_t       r;
        span = (line_len < LEN_MIN) ? LEN_MIN : ((line_len > LEN) ? LEN : line_len);
        nlines = (line_count > LINES) ? LINES : line_count;
        sum = '0;
        r.clipped = 1'b0;
        for (k = 0; k < nlines; k++)
        begin
            idx = band_step(p, k) + span / 2 + 1;
            if (idx < 0)
            begin
                idx = 0;
                r.clipped = 1'b1;
            end
            if (idx > span - 1)
            begin
                idx = span - 1;
                r.clipped = 1'b1;
            end
            s = sample_store[k * LEN + int'(idx)];
            sum = sum + {{(FV_W-SMP_W){s[SMP_W-1]}}, s};
        end
        np = (field_points == 0) ? PC_W'(1) : field_points;
        r.last_point = ({1'b0, point_pos} + 1) >= {1'b0, np};
        point_pos = r.last_point ? '0 : point_pos + 1'b1;
        r.field_value = sum;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tbfs_out_t want;
        if (!rst_n)
        begin
            res_factor   = RF_RESET;
            line_len     = LEN_RESET;
            line_count   = LINES_RESET;
            field_points = POINTS_RESET;
            point_pos    = '0;
            field_q.delete();
            errors       = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (tbfs_cfg_idx_t'(cfg_index))
                    CFG_RES_FACTOR:    res_factor   = cfg_data[RF_W-1:0];
                    CFG_LINE_LENGTH:   line_len     = cfg_data[LEN_W-1:0];
                    CFG_LINES_IN_USE:  line_count   = cfg_data[NL_W-1:0];
                    CFG_POINTS_IN_USE: field_points = cfg_data[PC_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                case (item.kind)
                    KIND_DIR:
                    begin
                        dir_store[item.line_index][0] = item.dir_x;
                        dir_store[item.line_index][1] = item.dir_y;
                        dir_store[item.line_index][2] = item.dir_z;
                    end
                    KIND_SAMPLE:
                        sample_store[{item.line_index, item.sample_index}] = item.sample_value;
                    KIND_POINT:
                        field_q.push_back(next_field(item));
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (field_q.size() == 0)
                    flag("result with no point pending", 64'(result), '0);
                else
                begin
                    want = field_q.pop_front();
                    if (result.field_value !== want.field_value)
                        flag("field_value", 64'(result.field_value), 64'(want.field_value));
                    if (result.clipped !== want.clipped)
                        flag("clipped", 64'(result.clipped), 64'(want.clipped));
                    if (result.last_point !== want.last_point)
                        flag("last_point", 64'(result.last_point), 64'(want.last_point));
                end
            end
            pending = field_q.size();
        end
    end

endmodule

// File: tb/testbench.sv
module testbench;
    import tbfs_pkg::*;

    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam int unsigned LINES       = 64;
    localparam int unsigned LEN         = 1024;
    localparam logic [31:0] DIR_ONE     = 32'h4000_0000;
    localparam logic [31:0] WORD_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN    = 32'h8000_0000;
    localparam int unsigned SETTLE      = 80;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    tbfs_in_t              item         = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    tbfs_out_t             result;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    int unsigned           errors;
    int unsigned           pending;

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_len  = 0;
    int unsigned cur_len   = LEN;
    int unsigned cur_lines = LINES;
    bit          dir_loaded [LINES];
    bit          sample_loaded [LINES][LEN];

    always #5 clk = ~clk;

    turning_bands_field_sum i_dut (.*);

    tbfs_checker i_checker (.*);

    initial
    begin
        #20_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_len != 0)
            begin
                hold_left = hold_len;
                hold_len = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic tbfs_in_t noise_item();
        tbfs_in_t it;
        it.kind         = 2'($urandom);
        it.line_index   = 6'($urandom);
        it.sample_index = 10'($urandom);
        it.dir_x        = $urandom;
        it.dir_y        = $urandom;
        it.dir_z        = $urandom;
        it.sample_value = $urandom;
        it.coord_x      = $urandom;
        it.coord_y      = $urandom;
        it.coord_z      = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] rand_dir();
        if ($urandom_range(9) < 7)
            return $signed($urandom) >>> 1;
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(9) < 6)
            return $signed($urandom) >>> $urandom_range(6, 20);
        return $urandom;
    endfunction

    task automatic send_item(input tbfs_in_t it);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        if (it.kind == KIND_DIR)
            dir_loaded[it.line_index] = 1'b1;
        if (it.kind == KIND_SAMPLE)
            sample_loaded[it.line_index][it.sample_index] = 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic send_dir(input int unsigned line, input logic [31:0] x, y, z);
        tbfs_in_t it;
        it = noise_item();
        it.kind       = KIND_DIR;
        it.line_index = 6'(line);
        it.dir_x      = x;
        it.dir_y      = y;
        it.dir_z      = z;
        send_item(it);
    endtask

    task automatic send_sample(input int unsigned line, input int unsigned pos,
                               input logic [31:0] v);
        tbfs_in_t it;
        it = noise_item();
        it.kind         = KIND_SAMPLE;
        it.line_index   = 6'(line);
        it.sample_index = 10'(pos);
        it.sample_value = v;
        send_item(it);
    endtask

    task automatic send_point(input logic [31:0] x, y, z);
        tbfs_in_t it;
        it = noise_item();
        it.kind    = KIND_POINT;
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        send_item(it);
    endtask

    task automatic send_random();
        int unsigned pick, line, pos;
        tbfs_in_t    it;
        pick = $urandom_range(99);
        line = (cur_lines != 0 && $urandom_range(1) == 1) ?
               $urandom_range(cur_lines - 1) : $urandom_range(LINES - 1);
        pos  = ($urandom_range(1) == 1) ? $urandom_range(cur_len - 1) : $urandom_range(LEN - 1);
        if (pick < 45)
            send_point(rand_coord(), rand_coord(), rand_coord());
        else if (pick < 65)
            send_dir(line, rand_dir(), rand_dir(), rand_dir());
        else if (pick < 95)
            send_sample(line, pos, $urandom);
        else
        begin
            it = noise_item();
            it.kind = KIND_UNUSED;
            send_item(it);
        end
    endtask

    task automatic write_reg(input tbfs_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [RF_W-1:0] rf, input logic [LEN_W-1:0] len,
                              input logic [NL_W-1:0] nl, input logic [PC_W-1:0] np);
        int unsigned k, s;
        // drop valid and let the last point drain before touching registers
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        write_reg(CFG_RES_FACTOR, CFG_DATA_W'(rf));
        write_reg(CFG_LINE_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_LINES_IN_USE, CFG_DATA_W'(nl));
        write_reg(CFG_POINTS_IN_USE, CFG_DATA_W'(np));
        cur_len   = (len < LEN_MIN) ? LEN_MIN : ((len > LEN) ? LEN : len);
        cur_lines = (nl > LINES) ? LINES : nl;
        // load every entry a point can now read
        for (k = 0; k < cur_lines; k++)
        begin
            if (!dir_loaded[k])
                send_dir(k, rand_dir(), rand_dir(), rand_dir());
            for (s = 0; s < cur_len; s++)
                if (!sample_loaded[k][s])
                    send_sample(k, s, $urandom);
        end
    endtask

    task automatic run_phase(input logic [RF_W-1:0] rf, input logic [LEN_W-1:0] len,
                             input logic [NL_W-1:0] nl, input logic [PC_W-1:0] np,
                             input int unsigned idle, input int unsigned stall,
                             input int unsigned n, input int unsigned hold);
        int unsigned i;
        set_config(rf, len, nl, np);
        idle_pct  = idle;
        stall_pct = stall;
        for (i = 0; i < n; i++)
        begin
            if (hold != 0 && i == n / 2)
                hold_len = hold;
            send_random();
        end
    endtask

    initial
    begin
        tbfs_in_t    odd;
        int unsigned waited;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        set_config(24'd65536, 11'd16, 7'd4, 24'd3);
        send_dir(0, DIR_ONE, 32'h0, 32'h0);
        send_dir(1, 32'h0, DIR_ONE, 32'h0);
        send_dir(2, 32'h0, 32'h0, 32'h0);
        send_dir(3, 32'h0, WORD_MIN, WORD_MAX);
        send_sample(0, 0, WORD_MAX);
        send_sample(0, 15, WORD_MIN);
        send_sample(1, 9, 32'h0);
        send_sample(LINES - 1, LEN - 1, $urandom);
        odd = noise_item();
        odd.kind = KIND_UNUSED;
        send_item(odd);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h0000_8000, 32'h0, 32'h0);
        send_point(32'hFFFF_8000, 32'h0, 32'h0);
        send_point(32'hFFFA_0000, 32'h0, 32'h0);
        send_point(32'hFFF9_0000, 32'h0, 32'h0);
        send_point(32'h0009_0000, 32'h0, 32'h0);
        send_point(32'h000A_0000, 32'h0, 32'h0);
        send_point(WORD_MAX, WORD_MAX, WORD_MAX);
        send_point(WORD_MIN, WORD_MIN, WORD_MIN);
        send_point(WORD_MAX, WORD_MIN, 32'h0);

        run_phase(24'd65536, 11'd32, 7'd4, 24'd5, 0, 0, 50, 0);
        run_phase(24'hFF_FFFF, 11'd2047, 7'd1, 24'd0, 59, 0, 50, 0);
        run_phase(24'd0, 11'd0, 7'd127, 24'hFF_FFFF, 0, 59, 50, 0);
        run_phase(24'($urandom), 11'd1, 7'd0, 24'd1, 18, 18, 40, 0);
        run_phase(24'd4096, 11'd4, 7'd64, 24'd7, 18, 18, 60, 600);
        run_phase(24'($urandom_range(1, 24'hFF_FFFF)), 11'd1023, 7'd1, 24'd2, 0, 0, 40, 0);

        @(negedge clk);
        item_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 200_000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: filelist.f
design/tbfs_pkg.sv
design/tbfs_proj.sv
design/tbfs_smp_store.sv
design/turning_bands_field_sum.sv
design/tbfs_checker.sv
tb/tbfs_checker.sv
tb/testbench.sv
